[rtl/assert_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, a, b, msg)
`define ASSERT_NEXT(lbl, clk, rst, a, b, msg)
`endif
`endif

[rtl/slp13_pkg.sv]
// Types, constants and arithmetic helpers of the 13-tap low-pass filter.
`default_nettype none
package slp13_pkg;
  localparam int TAPS          = 13;
  localparam int HALF          = 6;
  localparam int LINES         = 12;
  localparam int SRC_N         = LINES + 1;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int MIN_SIZE      = 13;
  localparam int PIX_W         = 8;
  localparam int SUM_W         = 16;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 4;
  localparam int ROW_W         = 12;
  localparam int SLOT_W        = 4;
  localparam int EDGE_W        = 3;
  localparam int RECIP_SHIFT   = 23;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_W-1:0]     RST_WIDTH        = 12'd720;
  localparam logic [CFG_W-1:0]     RST_HEIGHT       = 12'd576;
  // ceil(2^23 / 185): exact floor division for all sums below 2^18
  localparam logic [15:0]          RECIP_185        = 16'd45344;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic [EDGE_W-1:0] xl;
    logic [EDGE_W-1:0] xr;
  } hctl_t;

  typedef struct packed {
    logic [TAPS-1:0][SRC_N-1:0] sel;
    logic [PIX_W-1:0]           pix;
    hctl_t                      h;
  } vitem_t;

  function automatic logic [4:0] tap_weight(input logic [3:0] k);
    logic [4:0] w;
    case (k)
      4'd0, 4'd12: w = 5'd1;
      4'd1, 4'd11: w = 5'd6;
      4'd2, 4'd10: w = 5'd11;
      4'd3, 4'd9:  w = 5'd17;
      4'd4, 4'd8:  w = 5'd21;
      4'd5, 4'd7:  w = 5'd24;
      4'd6:        w = 5'd25;
      default:     w = 5'd0;
    endcase
    return w;
  endfunction

  function automatic logic [PIX_W-1:0] div185(input logic [SUM_W-1:0] n);
    logic [31:0] prod;
    prod = {16'd0, n} * {16'd0, RECIP_185};
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction
endpackage
`default_nettype wire

[rtl/slp13_ifs.sv]
// Channel interfaces: pixel input, filtered output and register writes.
`default_nettype none
interface slp13_in_if;
  logic                        valid;
  logic                        ready;
  logic [slp13_pkg::PIX_W-1:0] pixel_in;
  logic                        drain;
  modport source (output valid, pixel_in, drain, input ready);
  modport sink (input valid, pixel_in, drain, output ready);
endinterface

interface slp13_out_if;
  logic                        valid;
  logic                        ready;
  logic [slp13_pkg::PIX_W-1:0] pixel_out;
  logic                        frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

interface slp13_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slp13_pkg::CFG_IDX_W-1:0] index;
  logic [slp13_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/slp13_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slp13_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/slp13_ctrl.sv]
// Raster counters, frame size latch, line store addressing and tap selection.
`default_nettype none
`include "assert_macros.svh"
module slp13_ctrl #(
  parameter int MAX_WIDTH = slp13_pkg::MAX_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  slp13_in_if.sink                              src,
  slp13_cfg_if.sink                             cfg,
  input  logic                                  adv,
  output logic [slp13_pkg::LINES-1:0]           we,
  output logic [$clog2(MAX_WIDTH)-1:0]          addr,
  output logic [slp13_pkg::PIX_W-1:0]           wdata,
  output logic                                  s1_valid,
  output slp13_pkg::vitem_t                     s1_item
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (AW > slp13_pkg::CFG_W) ? AW : slp13_pkg::CFG_W;
  localparam int ROW_W = slp13_pkg::ROW_W;
  localparam int SW    = slp13_pkg::SLOT_W;

  logic [slp13_pkg::CFG_W-1:0] cfg_w, cfg_h;
  logic [AW-1:0]               act_w;
  logic [ROW_W-1:0]            act_h;
  logic [COL_W-1:0]            column_count, out_col;
  logic [ROW_W-1:0]            row_count, out_row;
  logic [SW-1:0]               row_slot, top_slot;

  logic [AW-1:0]     w_clamp, eff_w, rem;
  logic [ROW_W-1:0]  h_clamp, eff_h;
  logic [CMP_W-1:0]  cw_ext;
  logic              start, flushing, proc, accept, emit, last, col_end, out_col_end;
  logic [SW-1:0]     row_slot_inc;
  slp13_pkg::vitem_t s1_item_next;

  assign cfg.ready = 1'b1;
  assign src.ready = adv;
  assign accept    = src.valid && adv;
  assign addr      = column_count;
  assign wdata     = src.pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= slp13_pkg::RST_WIDTH;
      cfg_h <= slp13_pkg::RST_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        slp13_pkg::REG_FRAME_WIDTH:  cfg_w <= cfg.data;
        slp13_pkg::REG_FRAME_HEIGHT: cfg_h <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cw_ext = CMP_W'(cfg_w);
    if (cw_ext < CMP_W'(slp13_pkg::MIN_SIZE)) begin
      w_clamp = AW'(slp13_pkg::MIN_SIZE);
    end else if (cw_ext > CMP_W'(MAX_WIDTH)) begin
      w_clamp = AW'(MAX_WIDTH);
    end else begin
      w_clamp = AW'(cw_ext);
    end
    if (cfg_h < slp13_pkg::CFG_W'(slp13_pkg::MIN_SIZE)) begin
      h_clamp = ROW_W'(slp13_pkg::MIN_SIZE);
    end else if (cfg_h > slp13_pkg::CFG_W'(slp13_pkg::MAX_HEIGHT)) begin
      h_clamp = ROW_W'(slp13_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = ROW_W'(cfg_h);
    end
  end

  always_comb begin
    start    = (column_count == '0) && (row_count == '0) && !src.drain;
    eff_w    = start ? w_clamp : act_w;
    eff_h    = start ? h_clamp : act_h;
    flushing = row_count >= eff_h;
    // drop a drain that arrives before the frame's last pixel
    proc     = !(src.drain && !flushing);
    emit     = (row_count > ROW_W'(slp13_pkg::HALF)) ||
               ((row_count == ROW_W'(slp13_pkg::HALF)) &&
                (column_count >= COL_W'(slp13_pkg::HALF)));
    col_end     = (AW'(column_count) + AW'(1)) == eff_w;
    out_col_end = (AW'(out_col) + AW'(1)) == eff_w;
    last        = emit && out_col_end && (out_row == eff_h - ROW_W'(1));
    row_slot_inc = (row_slot == SW'(slp13_pkg::LINES - 1)) ? '0 : row_slot + SW'(1);
    for (int i = 0; i < slp13_pkg::LINES; i++) begin
      we[i] = accept && !flushing && !src.drain && (row_slot == SW'(i));
    end
  end

  // tap k covers row (row_count - 12 + k), clamped to the frame
  always_comb begin
    logic [ROW_W-1:0]            rk;
    logic                        lo, hi;
    logic [SW:0]                 sk;
    logic [slp13_pkg::SRC_N-1:0] sel_k;
    s1_item_next.pix  = src.pixel_in;
    s1_item_next.h.emit = emit;
    s1_item_next.h.last = last;
    s1_item_next.h.xl = (out_col >= COL_W'(slp13_pkg::HALF)) ?
                        slp13_pkg::EDGE_W'(slp13_pkg::HALF) : slp13_pkg::EDGE_W'(out_col);
    rem = eff_w - AW'(1) - AW'(out_col);
    s1_item_next.h.xr = (rem >= AW'(slp13_pkg::HALF)) ?
                        slp13_pkg::EDGE_W'(slp13_pkg::HALF) : slp13_pkg::EDGE_W'(rem);
    for (int k = 0; k < slp13_pkg::TAPS; k++) begin
      rk = row_count + ROW_W'(k);
      lo = rk < ROW_W'(slp13_pkg::LINES);
      hi = rk >= eff_h + ROW_W'(slp13_pkg::LINES);
      sk = {1'b0, row_slot} + (SW + 1)'(k);
      if (sk >= (SW + 1)'(slp13_pkg::LINES)) begin
        sk = sk - (SW + 1)'(slp13_pkg::LINES);
      end
      if (!flushing && ((k == slp13_pkg::TAPS - 1) || (lo && row_count == '0))) begin
        sel_k = slp13_pkg::SRC_N'(1) << slp13_pkg::LINES;
      end else if (lo) begin
        sel_k = slp13_pkg::SRC_N'(1);
      end else if (hi) begin
        sel_k = slp13_pkg::SRC_N'(1) << top_slot;
      end else begin
        sel_k = slp13_pkg::SRC_N'(1) << sk[SW-1:0];
      end
      s1_item_next.sel[k] = sel_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_w        <= AW'(slp13_pkg::RST_WIDTH);
      act_h        <= ROW_W'(slp13_pkg::RST_HEIGHT);
      column_count <= '0;
      row_count    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      row_slot     <= '0;
      top_slot     <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= accept && proc;
      end
      if (accept && proc) begin
        if (start) begin
          act_w <= w_clamp;
          act_h <= h_clamp;
        end
        if (!flushing) begin
          top_slot <= row_slot;
        end
        if (last) begin
          column_count <= '0;
          row_count    <= '0;
          out_col      <= '0;
          out_row      <= '0;
          row_slot     <= '0;
        end else begin
          if (col_end) begin
            column_count <= '0;
            row_count    <= row_count + ROW_W'(1);
            row_slot     <= row_slot_inc;
          end else begin
            column_count <= column_count + COL_W'(1);
          end
          if (emit) begin
            if (out_col_end) begin
              out_col <= '0;
              out_row <= out_row + ROW_W'(1);
            end else begin
              out_col <= out_col + COL_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= s1_item_next;
    end
  end

  `ASSERT_IMPL(a_col_range, clk, rst, 1'b1, AW'(column_count) < act_w, "column past frame width")
  `ASSERT_IMPL(a_slot_range, clk, rst, 1'b1, (row_slot < SW'(slp13_pkg::LINES)) && (top_slot < SW'(slp13_pkg::LINES)), "line slot out of range")
  `ASSERT_IMPL(a_one_write, clk, rst, 1'b1, $onehot0(we), "more than one line written")
endmodule
`default_nettype wire

[rtl/slp13_vert.sv]
// Vertical 13-tap sum, divide by 185 and the window of vertical results.
`default_nettype none
module slp13_vert (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            adv,
  input  logic                                            s1_valid,
  input  slp13_pkg::vitem_t                               s1_item,
  input  logic [slp13_pkg::LINES-1:0][slp13_pkg::PIX_W-1:0] rdata,
  output logic                                            s3_valid,
  output slp13_pkg::hctl_t                                s3_h,
  output logic [slp13_pkg::TAPS-1:0][slp13_pkg::PIX_W-1:0]  win
);
  logic                        s2_valid;
  logic [slp13_pkg::SUM_W-1:0] s2_vsum, vsum_next;
  slp13_pkg::hctl_t            s2_h;

  always_comb begin
    logic [slp13_pkg::PIX_W-1:0] tap;
    vsum_next = '0;
    for (int k = 0; k < slp13_pkg::TAPS; k++) begin
      tap = '0;
      for (int i = 0; i < slp13_pkg::LINES; i++) begin
        if (s1_item.sel[k][i]) begin
          tap = tap | rdata[i];
        end
      end
      if (s1_item.sel[k][slp13_pkg::LINES]) begin
        tap = tap | s1_item.pix;
      end
      vsum_next = vsum_next + slp13_pkg::SUM_W'(tap) *
                  slp13_pkg::SUM_W'(slp13_pkg::tap_weight(4'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      win      <= '0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      // advance the window only on real items
      if (s2_valid) begin
        for (int j = 0; j < slp13_pkg::TAPS - 1; j++) begin
          win[j] <= win[j + 1];
        end
        win[slp13_pkg::TAPS - 1] <= slp13_pkg::div185(s2_vsum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vsum <= vsum_next;
      s2_h    <= s1_item.h;
      s3_h    <= s2_h;
    end
  end
endmodule
`default_nettype wire

[rtl/slp13_horz.sv]
// Horizontal 13-tap sum with edge replication, divide and output skid stage.
`default_nettype none
`include "assert_macros.svh"
module slp13_horz (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s3_valid,
  input  slp13_pkg::hctl_t                                s3_h,
  input  logic [slp13_pkg::TAPS-1:0][slp13_pkg::PIX_W-1:0]  win,
  output logic                                            adv,
  slp13_out_if.source                                     dst
);
  localparam int HALF = slp13_pkg::HALF;
  localparam int EW   = slp13_pkg::EDGE_W;

  logic [slp13_pkg::PIX_W-1:0] ext [slp13_pkg::TAPS];
  logic [slp13_pkg::SUM_W-1:0] hsum_next, s4_hsum;
  logic                        s4_valid, s4_last;
  logic                        out_valid, out_last, skid_valid, skid_last, incoming;
  logic [slp13_pkg::PIX_W-1:0] out_pix, skid_pix, res_pix;

  // replicate the nearest in-row column past either edge
  always_comb begin
    ext[HALF] = win[HALF];
    for (int k = HALF - 1; k >= 0; k--) begin
      ext[k] = (EW'(HALF - k) <= s3_h.xl) ? win[k] : ext[k + 1];
    end
    for (int k = HALF + 1; k < slp13_pkg::TAPS; k++) begin
      ext[k] = (EW'(k - HALF) <= s3_h.xr) ? win[k] : ext[k - 1];
    end
    hsum_next = '0;
    for (int k = 0; k < slp13_pkg::TAPS; k++) begin
      hsum_next = hsum_next + slp13_pkg::SUM_W'(ext[k]) *
                  slp13_pkg::SUM_W'(slp13_pkg::tap_weight(4'(k)));
    end
  end

  assign adv      = !skid_valid;
  assign incoming = adv && s4_valid;
  assign res_pix  = slp13_pkg::div185(s4_hsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid   <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (adv) begin
        s4_valid <= s3_valid && s3_h.emit;
      end
      if (out_valid && !dst.ready) begin
        if (incoming) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        skid_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= incoming;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hsum <= hsum_next;
      s4_last <= s3_h.last;
    end
    if (out_valid && !dst.ready) begin
      if (incoming) begin
        skid_pix  <= res_pix;
        skid_last <= s4_last;
      end
    end else if (skid_valid) begin
      out_pix  <= skid_pix;
      out_last <= skid_last;
    end else if (incoming) begin
      out_pix  <= res_pix;
      out_last <= s4_last;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.pixel_out  = out_pix;
  assign dst.frame_last = out_last;

  `ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid holds a request ahead of output")
  `ASSERT_IMPL(a_last_emits, clk, rst, s3_valid && s3_h.last, s3_h.emit, "frame end on an item with no result")
  `ASSERT_IMPL(a_one_edge, clk, rst, s3_valid && s3_h.emit, (s3_h.xl == EW'(HALF)) || (s3_h.xr == EW'(HALF)), "both row edges inside one window")
endmodule
`default_nettype wire

[rtl/separable_13tap_lowpass_unit.sv]
// Top level of the separable 13-tap low-pass filter.
//
//  channel  role    handshake         payload
//  src      sink    valid / ready     pixel_in[7:0], drain
//  dst      source  valid / ready     pixel_out[7:0], frame_last
//  cfg      sink    valid / ready=1   index[3:0], data[11:0]
//
// One request per clock while the skid register is empty: line store reads, vertical sum,
// window, horizontal sum and output each take one register stage; a result is completed
// by the request 6 rows plus 6 pixels of requests after its own and then passes these stages.
// 6*W+6 drain requests after the last pixel flush the frame.
// Reset clears counters and the window; the line store needs no clearing pass.
// A stalled output fills a one-entry skid register; src.ready drops only then.
`default_nettype none
module separable_13tap_lowpass_unit #(
  parameter int MAX_WIDTH = slp13_pkg::MAX_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  slp13_in_if.sink     src,
  slp13_out_if.source  dst,
  slp13_cfg_if.sink    cfg
);
  logic                                              adv, s1_valid, s3_valid;
  logic [slp13_pkg::LINES-1:0]                       we;
  logic [$clog2(MAX_WIDTH)-1:0]                      addr;
  logic [slp13_pkg::PIX_W-1:0]                       wdata;
  logic [slp13_pkg::LINES-1:0][slp13_pkg::PIX_W-1:0] rdata;
  logic [slp13_pkg::TAPS-1:0][slp13_pkg::PIX_W-1:0]  win;
  slp13_pkg::vitem_t                                 s1_item;
  slp13_pkg::hctl_t                                  s3_h;

  slp13_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .src      (src),
    .cfg      (cfg),
    .adv      (adv),
    .we       (we),
    .addr     (addr),
    .wdata    (wdata),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  for (genvar i = 0; i < slp13_pkg::LINES; i++) begin : g_line
    slp13_ram #(.WIDTH(slp13_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (we[i]),
      .waddr (addr),
      .wdata (wdata),
      .re    (adv),
      .raddr (addr),
      .rdata (rdata[i])
    );
  end

  slp13_vert u_vert (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rdata    (rdata),
    .s3_valid (s3_valid),
    .s3_h     (s3_h),
    .win      (win)
  );

  slp13_horz u_horz (
    .clk      (clk),
    .rst      (rst),
    .s3_valid (s3_valid),
    .s3_h     (s3_h),
    .win      (win),
    .adv      (adv),
    .dst      (dst)
  );
endmodule
`default_nettype wire
